// File: src/mts_pkg.sv
// Shared types and constants for the min-tracking stack.
`default_nettype none
package mts_pkg;

	// Built size of the stack and word width
	localparam int unsigned DEPTH  = 64;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

	// Request opcodes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// One request
	typedef struct packed {
		logic  req_type;
		word_t push_value;
	} req_t;

	// One result
	typedef struct packed {
		word_t top_value;
		word_t min_value;
		cnt_t  entry_count;
		logic  is_empty;
		logic  is_full;
		logic  rejected;
	} rsp_t;

	// Shift control for one row of cells
	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctl_t;

endpackage
`default_nettype wire

// File: src/mts_cell.sv
// One stack cell: takes its upper neighbor's word on push, its lower neighbor's on pop.
`default_nettype none
module mts_cell (
	input  wire logic          clk,
	input  wire mts_pkg::stk_ctl_t ctl,
	input  wire mts_pkg::word_t    up_data,
	input  wire mts_pkg::word_t    dn_data,
	output mts_pkg::word_t         data
);
	import mts_pkg::*;

	word_t data_q;

	// Payload only, no reset
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			data_q <= up_data;
		end else if (ctl.pop) begin
			data_q <= dn_data;
		end
	end

	assign data = data_q;

endmodule
`default_nettype wire

// File: src/mts_chain.sv
// Row of stack cells; cell 0 is always the top of the stack.
`default_nettype none
module mts_chain (
	input  wire logic              clk,
	input  wire mts_pkg::stk_ctl_t ctl,
	input  wire mts_pkg::word_t    push_data,
	output mts_pkg::word_t         top
);
	import mts_pkg::*;

	word_t cell_data [DEPTH];

	// Each cell reads its two neighbors; the ends see the new word and zero
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t up_w;
		word_t dn_w;

		if (i == 0) begin : g_first
			assign up_w = push_data;
		end else begin : g_mid_up
			assign up_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign dn_w = '0;
		end else begin : g_mid_dn
			assign dn_w = cell_data[i+1];
		end

		mts_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.up_data (up_w),
			.dn_data (dn_w),
			.data    (cell_data[i])
		);
	end

	assign top = cell_data[0];

endmodule
`default_nettype wire

// File: src/min_tracking_stack.sv
// Top level of the min-tracking stack: control, counts and result register.
//
// Channel   Direction  Handshake           Payload
// request   in         start & !busy       req  (req_type, push_value)
// result    out        done, one cycle     rsp  (top, min, count, flags)
// config    in         cfg_we              cfg_data (capacity limit)
//
// Each request's result shows on rsp with done high in the cycle after
// acceptance. busy stays low, so a request can be taken every cycle. Both
// stacks are rows of cells that shift by one entry per request, so the tops
// sit in the first cell of each row. Reset clears the counts and loads the
// limit with the full depth; cell contents are not cleared. The receiver
// cannot stall: each result lasts one cycle.
`default_nettype none
module min_tracking_stack (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire mts_pkg::req_t     req,
	output logic                   done,
	output mts_pkg::rsp_t          rsp,
	input  wire logic              cfg_we,
	input  wire mts_pkg::cnt_t     cfg_data
);
	import mts_pkg::*;

	localparam cnt_t DEPTH_C = CNT_W'(DEPTH);

	cnt_t     main_cnt_q;
	cnt_t     min_cnt_q;
	cnt_t     limit_q;
	logic     done_q;
	logic     rej_q;
	word_t    main_top;
	word_t    min_top;
	cnt_t     eff_limit;
	logic     accept;
	logic     is_push;
	logic     full;
	logic     rej;
	stk_ctl_t main_ctl;
	stk_ctl_t min_ctl;

	// Both rows of cells
	mts_chain u_main (
		.clk       (clk),
		.ctl       (main_ctl),
		.push_data (req.push_value),
		.top       (main_top)
	);

	mts_chain u_min (
		.clk       (clk),
		.ctl       (min_ctl),
		.push_data (req.push_value),
		.top       (min_top)
	);

	// Limit saturates at the built depth
	assign eff_limit = (limit_q > DEPTH_C) ? DEPTH_C : limit_q;
	assign full      = (main_cnt_q >= eff_limit);
	assign accept    = start && !busy;
	assign is_push   = (req.req_type == OP_PUSH);
	assign busy      = 1'b0;

	// Shift decisions for both rows
	always_comb begin
		main_ctl = '0;
		min_ctl  = '0;
		rej      = 1'b0;
		if (accept) begin
			if (is_push) begin
				if (full) begin
					rej = 1'b1;
				end else begin
					main_ctl.push = 1'b1;
					if ((min_cnt_q == '0 || req.push_value <= min_top) &&
					    min_cnt_q < DEPTH_C) begin
						min_ctl.push = 1'b1;
					end
				end
			end else begin
				if (main_cnt_q == '0) begin
					rej = 1'b1;
				end else begin
					main_ctl.pop = 1'b1;
					if (min_cnt_q != '0 && main_top == min_top) begin
						min_ctl.pop = 1'b1;
					end
				end
			end
		end
	end

	// Counts, limit and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_cnt_q <= '0;
			min_cnt_q  <= '0;
			limit_q    <= DEPTH_C;
			done_q     <= 1'b0;
			rej_q      <= 1'b0;
		end else begin
			if (main_ctl.push) begin
				main_cnt_q <= main_cnt_q + 1'b1;
			end else if (main_ctl.pop) begin
				main_cnt_q <= main_cnt_q - 1'b1;
			end
			if (min_ctl.push) begin
				min_cnt_q <= min_cnt_q + 1'b1;
			end else if (min_ctl.pop) begin
				min_cnt_q <= min_cnt_q - 1'b1;
			end
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			done_q <= accept;
			if (accept) begin
				rej_q <= rej;
			end
		end
	end

	// Result reads the state left by the previous request
	assign done            = done_q;
	assign rsp.top_value   = (main_cnt_q != '0) ? main_top : '0;
	assign rsp.min_value   = (main_cnt_q != '0 && min_cnt_q != '0) ? min_top : '0;
	assign rsp.entry_count = main_cnt_q;
	assign rsp.is_empty    = (main_cnt_q == '0);
	assign rsp.is_full     = full;
	assign rsp.rejected    = rej_q;

	// Min row never holds more entries than the main row
	a_min_le_main: assert property (@(posedge clk) disable iff (!arst_n)
		min_cnt_q <= main_cnt_q)
		else $error("min count exceeds main count");

	// A non-empty stack always has a minimum
	a_min_present: assert property (@(posedge clk) disable iff (!arst_n)
		main_cnt_q != '0 |-> min_cnt_q != '0)
		else $error("main stack holds words but min stack is empty");

	// Each accepted request yields one result strobe next cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("missing result strobe");

	// A rejected request leaves the count alone
	a_rej_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && rej |=> main_cnt_q == $past(main_cnt_q) && rsp.rejected)
		else $error("rejected request changed the count");

endmodule
`default_nettype wire

// File: test/min_tracking_stack_test.sv
// Self-checking testbench for the min-tracking stack: directed and random requests.
module min_tracking_stack_test;
	import mts_pkg::*;

	// Tracks the expected stack contents and the expected result of each request
	class stack_scoreboard;
		word_t main_words[$];
		word_t min_words[$];
		cnt_t  limit_reg;
		rsp_t  expected_q[$];
		int    errors;
		int    checked;

		function new();
			limit_reg = cnt_t'(DEPTH);
			errors    = 0;
			checked   = 0;
		endfunction

		function void set_limit(cnt_t v);
			limit_reg = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Apply one accepted request and queue the result it should give
		function void note_request(req_t r);
			int    eff;
			logic  refused;
			word_t removed;
			rsp_t  want;
			eff     = (limit_reg > cnt_t'(DEPTH)) ? int'(DEPTH) : int'(limit_reg);
			refused = 1'b0;
			if (r.req_type == OP_PUSH) begin
				if (main_words.size() >= eff) begin
					refused = 1'b1;
				end else begin
					main_words.push_back(r.push_value);
					// ties go onto the min stack too, so duplicates pop cleanly
					if (min_words.size() == 0 || r.push_value <= min_words[$])
						min_words.push_back(r.push_value);
				end
			end else begin
				if (main_words.size() == 0) begin
					refused = 1'b1;
				end else begin
					removed = main_words.pop_back();
					if (min_words.size() != 0 && removed == min_words[$])
						void'(min_words.pop_back());
				end
			end
			want.top_value   = (main_words.size() != 0) ? main_words[$] : '0;
			want.min_value   = (main_words.size() != 0 && min_words.size() != 0) ?
				min_words[$] : '0;
			want.entry_count = cnt_t'(main_words.size());
			want.is_empty    = (main_words.size() == 0);
			want.is_full     = (main_words.size() >= eff);
			want.rejected    = refused;
			expected_q.push_back(want);
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		// Compare one result with the oldest expectation
		task check_result(rsp_t got);
			rsp_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result with nothing expected: %h", got));
				return;
			end
			want = expected_q.pop_front();
			if (got.top_value !== want.top_value)
				report($sformatf("result %0d top_value %h, expected %h",
					checked, got.top_value, want.top_value));
			if (got.min_value !== want.min_value)
				report($sformatf("result %0d min_value %h, expected %h",
					checked, got.min_value, want.min_value));
			if (got.entry_count !== want.entry_count)
				report($sformatf("result %0d entry_count %0d, expected %0d",
					checked, got.entry_count, want.entry_count));
			if (got.is_empty !== want.is_empty)
				report($sformatf("result %0d is_empty %b, expected %b",
					checked, got.is_empty, want.is_empty));
			if (got.is_full !== want.is_full)
				report($sformatf("result %0d is_full %b, expected %b",
					checked, got.is_full, want.is_full));
			if (got.rejected !== want.rejected)
				report($sformatf("result %0d rejected %b, expected %b",
					checked, got.rejected, want.rejected));
			checked++;
		endtask
	endclass

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  req;
	logic  done;
	rsp_t  rsp;
	logic  cfg_we;
	cnt_t  cfg_data;

	stack_scoreboard sb;

	min_tracking_stack i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watch both handshakes on the same edge the block sees them
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_request(req);
			if (done)
				sb.check_result(rsp);
		end
	end

	// Present one request and hold it until it is taken
	task automatic send(input logic op, input word_t v);
		start          <= 1'b1;
		req.req_type   <= op;
		req.push_value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Random burst of idle cycles between requests
	task automatic maybe_idle(input bit idle_ok);
		if (idle_ok && $urandom_range(3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13))
				@(posedge clk);
		end
	endtask

	// Write the capacity limit once all results are in
	task automatic write_limit(input cnt_t v);
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(v);
	endtask

	// Mostly small words so ties with the minimum are frequent
	function automatic req_t make_request(input int unsigned push_pct);
		req_t        r;
		int unsigned pick;
		r.req_type = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
		pick       = $urandom_range(9);
		if (pick < 5)
			r.push_value = word_t'($urandom_range(15));
		else if (pick < 7)
			r.push_value = word_t'($urandom);
		else if (pick == 7)
			r.push_value = '0;
		else if (pick == 8)
			r.push_value = '1;
		else
			r.push_value = word_t'($urandom_range(1000));
		return r;
	endfunction

	// Stimulus
	initial begin
		int unsigned phase_limit[10];
		int unsigned phase_push[10];
		int unsigned phase_len[10];
		bit          phase_idle[10];
		req_t        r;
		int          wait_cycles;

		phase_limit = '{64, 127, 3, 1, 0, 2, 45, 64, 17, 0};
		phase_push  = '{85, 85, 40, 50, 50, 60, 70, 30, 55, 50};
		phase_len   = '{80, 40, 50, 40, 20, 40, 50, 80, 50, 50};
		phase_idle  = '{1, 0, 1, 1, 1, 0, 1, 1, 1, 0};
		phase_limit[9] = $urandom_range(1, 127);

		sb       = new();
		start    <= 1'b0;
		req      <= '0;
		cfg_we   <= 1'b0;
		cfg_data <= '0;
		arst_n   <= 1'b0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;

		// Pop on empty, then extremes and a duplicate minimum
		send(OP_POP, '0);             maybe_idle(1);
		send(OP_PUSH, 32'hFFFF_FFFF); maybe_idle(1);
		send(OP_PUSH, 32'h0000_0000); maybe_idle(1);
		send(OP_PUSH, 32'h0000_0000); maybe_idle(1);
		send(OP_PUSH, 32'h0000_0005); maybe_idle(1);

		// Limit lowered below the count: pushes refused, pops drain
		write_limit(cnt_t'(1));
		send(OP_PUSH, 32'h0000_0009); maybe_idle(1);
		send(OP_POP, '0);             maybe_idle(1);
		send(OP_POP, '0);             maybe_idle(1);
		send(OP_POP, '0);             maybe_idle(1);
		send(OP_POP, '0);             maybe_idle(1);
		send(OP_POP, '0);             maybe_idle(1);

		// Small limit: fill, push on full, drain
		write_limit(cnt_t'(2));
		send(OP_PUSH, 32'h0000_0007); maybe_idle(1);
		send(OP_PUSH, 32'h0000_0003); maybe_idle(1);
		send(OP_PUSH, 32'h0000_0009); maybe_idle(1);
		send(OP_POP, '0);             maybe_idle(1);
		send(OP_POP, '0);             maybe_idle(1);

		// Zero limit: always full, nothing fits
		write_limit(cnt_t'(0));
		send(OP_PUSH, 32'h0000_0001); maybe_idle(1);
		send(OP_POP, '0);             maybe_idle(1);

		// Limit above the built depth saturates; alternating bit patterns
		write_limit(cnt_t'(127));
		send(OP_PUSH, 32'hA5A5_A5A5); maybe_idle(1);
		send(OP_PUSH, 32'h5A5A_5A5A); maybe_idle(1);
		send(OP_POP, '0);             maybe_idle(1);
		send(OP_POP, '0);             maybe_idle(1);

		// Random phases; the stack carries over from one limit to the next
		for (int p = 0; p < 10; p++) begin
			write_limit(cnt_t'(phase_limit[p]));
			for (int unsigned n = 0; n < phase_len[p]; n++) begin
				r = make_request(phase_push[p]);
				send(r.req_type, r.push_value);
				maybe_idle(phase_idle[p]);
			end
		end

		// Drain outstanding results, then report any that never arrived
		start <= 1'b0;
		@(posedge clk);
		wait_cycles = 0;
		while (sb.pending() != 0 && wait_cycles < 100) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (4)
			@(posedge clk);
		while (sb.pending() != 0) begin
			sb.report("expected result never arrived");
			void'(sb.expected_q.pop_front());
		end

		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Run limit
	initial begin
		#400000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
